>>> rtl/ffha_pkg.sv
// Package with the shared types, codes and sizes of the first-fit heap allocator.
`default_nettype none

package ffha_pkg;

   // Heap geometry: bytes, granules of one alignment unit, one granule of header.
   localparam int HEAP_BYTES    = 1024;
   localparam int ALIGN_BYTES   = 16;
   localparam int GRAN_BITS     = $clog2(ALIGN_BYTES);
   localparam int HEAP_GRANULES = HEAP_BYTES / ALIGN_BYTES;
   localparam int SEG_ADDR_BITS = $clog2(HEAP_GRANULES);
   localparam int PTR_BITS      = SEG_ADDR_BITS + 1;
   localparam int ADDR_BITS     = 10;
   localparam int REQ_BITS      = 10;

   // Command codes.
   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // Status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT   = 2'd1;
   localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;

   // One request as it enters the block.
   typedef struct packed {
      logic [1:0]          command;
      logic [REQ_BITS-1:0] request_bytes;
      logic [ADDR_BITS-1:0] free_address;
   } req_type;

   // One result as it leaves the block.
   typedef struct packed {
      logic [ADDR_BITS-1:0] data_address;
      logic [1:0]           status;
   } rsp_type;

   // A segment header: in-use flag and data size in granules.
   typedef struct packed {
      logic                     used;
      logic [SEG_ADDR_BITS-1:0] size;
   } seg_entry_type;

   // Outcome of evaluating one segment during a walk.
   typedef struct packed {
      logic                     hit;
      logic                     split;
      logic [SEG_ADDR_BITS-1:0] kept_size;
      logic [SEG_ADDR_BITS-1:0] rest;
      logic [PTR_BITS-1:0]      sum;
   } step_result_type;

   // Reset value of the first header: one free segment over the whole heap.
   localparam seg_entry_type RESET_HEAD = '{used: 1'b0,
                                            size: SEG_ADDR_BITS'(HEAP_GRANULES - 1)};

endpackage

`default_nettype wire

>>> rtl/ffha_seg_store.sv
// Segment header store: first header in flip-flops, the others in a memory.
`default_nettype none

module ffha_seg_store (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   clear_en,
   input  wire logic [ffha_pkg::SEG_ADDR_BITS-1:0]     rd_addr,
   output ffha_pkg::seg_entry_type                     rd_entry,
   input  wire logic                                   wr_en,
   input  wire logic [ffha_pkg::SEG_ADDR_BITS-1:0]     wr_addr,
   input  wire ffha_pkg::seg_entry_type                wr_entry
);

   ffha_pkg::seg_entry_type head_ff;
   ffha_pkg::seg_entry_type rdata_ff;
   logic                    sel_head_ff;
   ffha_pkg::seg_entry_type mem [ffha_pkg::HEAP_GRANULES];

   // The header at granule zero always exists and has a reset value.
   always_ff @(posedge clock) begin
      if (reset || clear_en) begin
         head_ff <= ffha_pkg::RESET_HEAD;
      end else if (wr_en && (wr_addr == '0)) begin
         head_ff <= wr_entry;
      end
   end

   // Headers further up are only ever reached after they have been written.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr != '0)) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   // Registered read; the flag remembers whether the head was addressed.
   always_ff @(posedge clock) begin
      rdata_ff    <= mem[rd_addr];
      sel_head_ff <= (rd_addr == '0);
   end

   assign rd_entry = sel_head_ff ? head_ff : rdata_ff;

endmodule

`default_nettype wire

>>> rtl/ffha_step_unit.sv
// Shared step unit: fit, split and address match for one segment, plus the walk adder.
`default_nettype none

module ffha_step_unit (
   input  wire ffha_pkg::seg_entry_type           entry,
   input  wire logic [ffha_pkg::PTR_BITS-1:0]     ptr,
   input  wire logic                              is_alloc,
   input  wire logic [ffha_pkg::PTR_BITS-1:0]     padded,
   input  wire logic                              free_aligned,
   input  wire logic [ffha_pkg::SEG_ADDR_BITS-1:0] free_gran,
   output ffha_pkg::step_result_type              result
);

   localparam int PB = ffha_pkg::PTR_BITS;
   localparam int SB = ffha_pkg::SEG_ADDR_BITS;

   logic [PB-1:0] size_wide;
   logic [PB-1:0] addend;
   logic          fits;
   logic          addr_match;

   always_comb begin
      size_wide = {1'b0, entry.size};

      // An allocate fits a free segment at least as large as the padded request.
      fits = !entry.used && (size_wide >= padded);

      // A free matches when the data offset lands just behind this header.
      addr_match = free_aligned && ({1'b0, free_gran} == PB'(ptr + PB'(1)));

      result.hit = is_alloc ? fits : addr_match;

      // Split only when a header and one granule remain behind the grant.
      result.split = is_alloc && (size_wide >= PB'(padded + PB'(2)));

      result.kept_size = (is_alloc && result.split) ? padded[SB-1:0] : entry.size;
      result.rest      = SB'(entry.size - padded[SB-1:0] - SB'(1));

      // One adder serves both the walk to the next header and the split position.
      addend     = (is_alloc && fits) ? padded : size_wide;
      result.sum = PB'(ptr + PB'(1) + addend);
   end

endmodule

`default_nettype wire

>>> rtl/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator: sequencer, result register and checks.
`default_nettype none

// A request is taken when start is high and busy is low. Allocate and free walk the
// segment headers from the bottom of the heap; each header visited takes a registered
// read of the header memory and then an evaluation in the shared step unit, and a
// split adds a further state for the second header write. There are at most 32 headers
// at the default heap size. Clear, a null free and an unknown command answer in the
// cycle after they are taken. Each result is shown for exactly one cycle with rsp_valid
// high and must be captured then, since the receiver cannot stall the block; busy is
// already low in that cycle, so the next request may be started alongside it.
module first_fit_heap_allocator_top (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire ffha_pkg::req_type req_data,
   output logic               rsp_valid,
   output ffha_pkg::rsp_type  rsp_data
);

   localparam int PB = ffha_pkg::PTR_BITS;
   localparam int SB = ffha_pkg::SEG_ADDR_BITS;
   localparam int GB = ffha_pkg::GRAN_BITS;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_EVAL  = 2'd2;
   localparam logic [1:0] ST_SPLIT = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [PB-1:0]             ptr_ff, ptr_in;
   logic                      is_alloc_ff, is_alloc_in;
   logic [PB-1:0]             padded_ff, padded_in;
   logic                      free_aligned_ff, free_aligned_in;
   logic [SB-1:0]             free_gran_ff, free_gran_in;
   logic [SB-1:0]             split_addr_ff, split_addr_in;
   logic [SB-1:0]             rest_ff, rest_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   ffha_pkg::rsp_type         rsp_data_ff, rsp_data_in;

   logic                      clear_en;
   logic                      wr_en;
   logic [SB-1:0]             wr_addr;
   ffha_pkg::seg_entry_type   wr_entry;
   ffha_pkg::seg_entry_type   rd_entry;
   ffha_pkg::step_result_type step;
   logic [PB-1:0]             req_gran;
   logic [SB-1:0]             grant_gran;
   logic [ffha_pkg::ADDR_BITS-1:0] grant_address;

   ffha_seg_store u_store (
      .clock    (clock),
      .reset    (reset),
      .clear_en (clear_en),
      .rd_addr  (ptr_ff[SB-1:0]),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry)
   );

   ffha_step_unit u_step (
      .entry        (rd_entry),
      .ptr          (ptr_ff),
      .is_alloc     (is_alloc_ff),
      .padded       (padded_ff),
      .free_aligned (free_aligned_ff),
      .free_gran    (free_gran_ff),
      .result       (step)
   );

   // Request size rounded up to whole granules, and never less than one.
   always_comb begin
      req_gran = PB'(req_data.request_bytes[ffha_pkg::REQ_BITS-1:GB])
               + PB'(|req_data.request_bytes[GB-1:0]);
      if (req_gran == '0) begin
         req_gran = PB'(1);
      end
   end

   // Data offset of the segment under the walk pointer.
   assign grant_gran    = SB'(ptr_ff[SB-1:0] + SB'(1));
   assign grant_address = {grant_gran, {GB{1'b0}}};

   // Sequencer: accept, walk the headers, write back, answer.
   always_comb begin
      state_in        = state_ff;
      ptr_in          = ptr_ff;
      is_alloc_in     = is_alloc_ff;
      padded_in       = padded_ff;
      free_aligned_in = free_aligned_ff;
      free_gran_in    = free_gran_ff;
      split_addr_in   = split_addr_ff;
      rest_in         = rest_ff;
      rsp_valid_in    = 1'b0;
      rsp_data_in     = rsp_data_ff;
      clear_en        = 1'b0;
      wr_en           = 1'b0;
      wr_addr         = ptr_ff[SB-1:0];
      wr_entry        = '{used: is_alloc_ff, size: step.kept_size};

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               is_alloc_in     = (req_data.command == ffha_pkg::CMD_ALLOC);
               padded_in       = req_gran;
               free_aligned_in = (req_data.free_address[GB-1:0] == '0);
               free_gran_in    = req_data.free_address[ffha_pkg::ADDR_BITS-1:GB];
               ptr_in          = '0;
               rsp_data_in     = '{data_address: '0, status: ffha_pkg::STATUS_OK};
               unique case (req_data.command)
                  ffha_pkg::CMD_ALLOC: begin
                     state_in = ST_READ;
                  end
                  ffha_pkg::CMD_FREE: begin
                     if (req_data.free_address == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  ffha_pkg::CMD_CLEAR: begin
                     clear_en     = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (step.hit) begin
               wr_en = 1'b1;
               if (is_alloc_ff && step.split) begin
                  split_addr_in = step.sum[SB-1:0];
                  rest_in       = step.rest;
                  state_in      = ST_SPLIT;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{data_address: is_alloc_ff ? grant_address : '0,
                                   status: ffha_pkg::STATUS_OK};
                  state_in     = ST_IDLE;
               end
            end else if (step.sum == PB'(ffha_pkg::HEAP_GRANULES)) begin
               // Walked past the last segment without success.
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{data_address: '0,
                                status: is_alloc_ff ? ffha_pkg::STATUS_NO_FIT
                                                    : ffha_pkg::STATUS_BAD_ADDR};
               state_in     = ST_IDLE;
            end else begin
               ptr_in   = step.sum;
               state_in = ST_READ;
            end
         end
         ST_SPLIT: begin
            // The remainder becomes a free segment right behind the grant.
            wr_en        = 1'b1;
            wr_addr      = split_addr_ff;
            wr_entry     = '{used: 1'b0, size: rest_ff};
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{data_address: grant_address, status: ffha_pkg::STATUS_OK};
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ptr_ff          <= ptr_in;
      is_alloc_ff     <= is_alloc_in;
      padded_ff       <= padded_in;
      free_aligned_ff <= free_aligned_in;
      free_gran_ff    <= free_gran_in;
      split_addr_ff   <= split_addr_in;
      rest_ff         <= rest_in;
      rsp_data_ff     <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // A result is only given once the sequencer has returned to idle.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // An allocate always walks at least one header.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.command == ffha_pkg::CMD_ALLOC)) |=> busy)
      else $error("allocate answered without a walk");

   // The cycle that writes a split remainder is followed by the grant.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPLIT) |=> (rsp_valid && (rsp_data.status == ffha_pkg::STATUS_OK)))
      else $error("split not followed by a grant");

   // Clear answers in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.command == ffha_pkg::CMD_CLEAR)) |=> rsp_valid)
      else $error("clear not answered at once");
`endif

endmodule

`default_nettype wire
